// File: hdl/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg: shared types and constants for the biquad highpass unit
// Field widths, register indexes and the control bundle of the serial
// shift-add multiplier.
// ----------------------------------------------------------------------------
package bq_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int GAIN_W     = 20;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // serial multiplier widths
   localparam int DIGIT_SR_W = 20;   // coefficient shift register, left aligned
   localparam int OP_W       = 40;   // multiplicand width
   localparam int ACC_W      = 60;   // accumulator width

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A1  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A2  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B0  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_OUT_GAIN = CSR_IDX_W'(3);

   // configuration bundle
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
      logic signed [COEF_W-1:0] coef_b0;
      logic        [GAIN_W-1:0] out_gain;
   } cfg_type;

   // serial multiplier control
   typedef struct packed {
      logic load;   // load accumulator and coefficient shift registers
      logic step;   // consume one coefficient bit
      logic sub;    // subtract the selected multiplicand on this step
   } smac_ctl_type;

endpackage

// File: hdl/bq_ifs.sv
// ----------------------------------------------------------------------------
// bq_ifs: channel interfaces of the biquad highpass unit
// Request and response sample streams and the register write channel.
// ----------------------------------------------------------------------------
interface bq_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bq_pkg::SAMPLE_W-1:0]  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bq_pkg::SAMPLE_W-1:0]  sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface bq_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bq_pkg::CSR_IDX_W-1:0]      index;
   logic [bq_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/bq_csr.sv
// ----------------------------------------------------------------------------
// bq_csr: coefficient and gain registers
// Takes register writes; unknown indexes are dropped, excess bits ignored.
// ----------------------------------------------------------------------------
module bq_csr (
   input  logic            clock,
   input  logic            reset,
   bq_csr_if.sink          csr_if,
   output bq_pkg::cfg_type cfg
);
   import bq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // always ready for a write
   assign csr_if.ready = 1'b1;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_COEF_A1:  cfg_in.coef_a1  = csr_if.data[COEF_W-1:0];
            REG_COEF_A2:  cfg_in.coef_a2  = csr_if.data[COEF_W-1:0];
            REG_COEF_B0:  cfg_in.coef_b0  = csr_if.data[COEF_W-1:0];
            REG_OUT_GAIN: cfg_in.out_gain = csr_if.data[GAIN_W-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a1  <= '0;
         cfg_ff.coef_a2  <= '0;
         cfg_ff.coef_b0  <= COEF_W'(65536);
         cfg_ff.out_gain <= GAIN_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/bq_smac.sv
// ----------------------------------------------------------------------------
// bq_smac: bit-serial shift-add multiply-accumulate unit
// Two coefficients shift out msb first, one bit each per cycle with step set;
// the bit pair picks one of three multiplicands or zero; acc = 2*acc +/- addend.
// ----------------------------------------------------------------------------
module bq_smac (
   input  logic                             clock,
   input  bq_pkg::smac_ctl_type             ctl,
   input  logic signed [bq_pkg::ACC_W-1:0]  init,
   input  logic [bq_pkg::DIGIT_SR_W-1:0]    coef_a,
   input  logic [bq_pkg::DIGIT_SR_W-1:0]    coef_b,
   input  logic signed [bq_pkg::OP_W-1:0]   op_a,
   input  logic signed [bq_pkg::OP_W-1:0]   op_b,
   input  logic signed [bq_pkg::OP_W-1:0]   op_ab,
   output logic signed [bq_pkg::ACC_W-1:0]  acc
);
   import bq_pkg::*;

   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic [DIGIT_SR_W-1:0]        sr_a_ff;
   logic [DIGIT_SR_W-1:0]        sr_a_in;
   logic [DIGIT_SR_W-1:0]        sr_b_ff;
   logic [DIGIT_SR_W-1:0]        sr_b_in;
   logic signed [ACC_W-1:0]      addend;
   logic signed [ACC_W-1:0]      doubled;

   // multiplicand select by the current bit pair
   always_comb begin
      case ({sr_a_ff[DIGIT_SR_W-1], sr_b_ff[DIGIT_SR_W-1]})
         2'b10:   addend = ACC_W'(op_a);
         2'b01:   addend = ACC_W'(op_b);
         2'b11:   addend = ACC_W'(op_ab);
         default: addend = '0;
      endcase
   end

   // horner step: acc = 2*acc +/- addend
   assign doubled = acc_ff <<< 1;

   always_comb begin
      acc_in  = acc_ff;
      sr_a_in = sr_a_ff;
      sr_b_in = sr_b_ff;
      if (ctl.load) begin
         acc_in  = init;
         sr_a_in = coef_a;
         sr_b_in = coef_b;
      end else if (ctl.step) begin
         acc_in  = ctl.sub ? (doubled - addend) : (doubled + addend);
         sr_a_in = {sr_a_ff[DIGIT_SR_W-2:0], 1'b0};
         sr_b_in = {sr_b_ff[DIGIT_SR_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sr_a_ff <= sr_a_in;
      sr_b_ff <= sr_b_in;
   end

   assign acc = acc_ff;

endmodule

// File: hdl/biquad_highpass_df2_unit.sv
// ----------------------------------------------------------------------------
// biquad_highpass_df2_unit: direct-form-II biquad highpass, fixed point
// Sequencer, delay line and output register around a bit-serial multiplier.
// ----------------------------------------------------------------------------
// One signed 16-bit sample goes in per request and one filtered sample comes
// out. The shared bit-serial multiplier consumes one coefficient bit per
// cycle in the a1/a2 feedback pass, the b0 pass and the gain pass, each
// followed by a rounding step; a mix step after the first rounding forms
// the feedforward sum, and only the idle state takes the next request. The
// final rounding step writes the result into the output register, and a
// new request is taken while the previous result still waits there; the
// result register is only reloaded once it is free, and the final rounding
// step holds until then. The user writes registers through the csr channel
// only while idle; the block does not enforce it. Index 0 a1, 1 a2, 2 b0
// (signed Q2.16), 3 output gain (unsigned Q4.16). Delay words and the output
// saturate; all roundings are half up.
module biquad_highpass_df2_unit (
   input  logic    clock,
   input  logic    reset,
   bq_req_if.sink  req_if,
   bq_rsp_if.source rsp_if,
   bq_csr_if.sink  csr_if
);
   import bq_pkg::*;

   localparam int Z_W         = 32;
   localparam int W_W         = 35;
   localparam int V_W         = 37;
   localparam int CNT_W       = 5;
   localparam int COEF_STEPS  = COEF_W;
   localparam int GAIN_STEPS  = GAIN_W;

   localparam logic signed [ACC_W-1:0] HALF_16 = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] HALF_24 = ACC_W'(8388608);
   localparam logic signed [ACC_W-1:0] M_MAX   = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] M_MIN   = ~M_MAX;
   localparam logic signed [ACC_W-1:0] Y_MAX   = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Y_MIN   = ~Y_MAX;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FEED   = 8'b0000_0010,
      ST_ROUND1 = 8'b0000_0100,
      ST_MIX    = 8'b0000_1000,
      ST_SCALE  = 8'b0001_0000,
      ST_ROUND2 = 8'b0010_0000,
      ST_GAIN   = 8'b0100_0000,
      ST_ROUND3 = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      first_ff, first_in;
   logic signed [Z_W-1:0]     z1_ff, z1_in;
   logic signed [Z_W-1:0]     z2_ff, z2_in;
   logic signed [Z_W-1:0]     m_ff, m_in;
   logic signed [W_W-1:0]     w_ff, w_in;
   logic signed [V_W-1:0]     v_ff, v_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   cfg_type                   cfg;
   smac_ctl_type              ctl;
   logic signed [ACC_W-1:0]   smac_init;
   logic [DIGIT_SR_W-1:0]     smac_coef_a;
   logic [DIGIT_SR_W-1:0]     smac_coef_b;
   logic signed [OP_W-1:0]    smac_op_a;
   logic signed [OP_W-1:0]    smac_op_b;
   logic signed [OP_W-1:0]    smac_op_ab;
   logic signed [ACC_W-1:0]   acc;

   logic                      accept;
   logic                      out_free;
   logic signed [ACC_W-1:0]   sh16;
   logic signed [ACC_W-1:0]   sh24;
   logic signed [W_W-1:0]     w_calc;

   // register file
   bq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // shared serial multiplier
   bq_smac u_smac (
      .clock  (clock),
      .ctl    (ctl),
      .init   (smac_init),
      .coef_a (smac_coef_a),
      .coef_b (smac_coef_b),
      .op_a   (smac_op_a),
      .op_b   (smac_op_b),
      .op_ab  (smac_op_ab),
      .acc    (acc)
   );

   // handshakes
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // rounding shifts of the accumulator
   assign sh16 = (acc + HALF_16) >>> 16;
   assign sh24 = (acc + HALF_24) >>> 24;

   // feedforward sum m - 2*z1 + z2
   assign w_calc = W_W'(m_ff) - (W_W'(z1_ff) <<< 1) + W_W'(z2_ff);

   // multiplier operands and control
   always_comb begin
      ctl.load    = accept || (state_ff == ST_MIX) || (state_ff == ST_ROUND2);
      ctl.step    = (state_ff == ST_FEED) || (state_ff == ST_SCALE)
                    || (state_ff == ST_GAIN);
      ctl.sub     = 1'b0;
      smac_init   = '0;
      smac_coef_a = '0;
      smac_coef_b = '0;
      smac_op_a   = OP_W'(z1_ff);
      smac_op_b   = OP_W'(z2_ff);
      smac_op_ab  = OP_W'(z1_ff) + OP_W'(z2_ff);
      unique case (state_ff) inside
         ST_IDLE: begin
            // x * 2^24 arrives after 18 doublings
            smac_init   = ACC_W'(req_if.sample_in) <<< 6;
            smac_coef_a = {cfg.coef_a1, {(DIGIT_SR_W-COEF_W){1'b0}}};
            smac_coef_b = {cfg.coef_a2, {(DIGIT_SR_W-COEF_W){1'b0}}};
         end
         ST_FEED: begin
            // feedback is subtracted; the sign bit weight flips it
            ctl.sub = !first_ff;
         end
         ST_MIX: begin
            smac_coef_a = {cfg.coef_b0, {(DIGIT_SR_W-COEF_W){1'b0}}};
         end
         ST_SCALE: begin
            smac_op_a = OP_W'(w_ff);
            ctl.sub   = first_ff;
         end
         ST_ROUND2: begin
            smac_coef_a = cfg.out_gain;
         end
         ST_GAIN: begin
            smac_op_a = OP_W'(v_ff);
         end
         ST_ROUND1, ST_ROUND3: begin
            ctl.sub = 1'b0;
         end
         default: begin
            ctl.sub = 1'b0;
         end
      endcase
   end

   // sequencer and datapath registers
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      m_in         = m_ff;
      w_in         = w_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.step) begin
         first_in = 1'b0;
         cnt_in   = cnt_ff - CNT_W'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FEED;
               cnt_in   = CNT_W'(COEF_STEPS - 1);
               first_in = 1'b1;
            end
         end
         ST_FEED: begin
            if (cnt_ff == '0) state_in = ST_ROUND1;
         end
         ST_ROUND1: begin
            // saturate the new delay word
            if (sh16 > M_MAX) begin
               m_in = M_MAX[Z_W-1:0];
            end else if (sh16 < M_MIN) begin
               m_in = M_MIN[Z_W-1:0];
            end else begin
               m_in = sh16[Z_W-1:0];
            end
            state_in = ST_MIX;
         end
         ST_MIX: begin
            w_in     = w_calc;
            z2_in    = z1_ff;
            z1_in    = m_ff;
            cnt_in   = CNT_W'(COEF_STEPS - 1);
            first_in = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (cnt_ff == '0) state_in = ST_ROUND2;
         end
         ST_ROUND2: begin
            v_in     = sh16[V_W-1:0];
            cnt_in   = CNT_W'(GAIN_STEPS - 1);
            first_in = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (cnt_ff == '0) state_in = ST_ROUND3;
         end
         ST_ROUND3: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sh24 > Y_MAX) begin
                  rsp_data_in = Y_MAX[SAMPLE_W-1:0];
               end else if (sh24 < Y_MIN) begin
                  rsp_data_in = Y_MIN[SAMPLE_W-1:0];
               end else begin
                  rsp_data_in = sh24[SAMPLE_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         z1_ff        <= '0;
         z2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         z1_ff        <= z1_in;
         z2_ff        <= z2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      w_ff        <= w_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

   // a request starts the feedback pass with a fresh sign step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FEED) && first_ff
                 && (cnt_ff == CNT_W'(COEF_STEPS - 1)))
      else $error("request did not start the feedback pass");

   // a response only appears out of the final rounding step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_ROUND3)
      else $error("response raised outside final rounding");

   // the delay line only moves once per sample
   a_delay_shift: assert property (@(posedge clock) disable iff (reset)
      (!$stable(z1_ff) && !$past(reset)) |-> $past(state_ff) == ST_MIX)
      else $error("delay word changed outside the mix step");

   // a stalled response holds the sequencer in the final step
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND3 && rsp_valid_ff && !rsp_if.ready)
      |=> state_ff == ST_ROUND3)
      else $error("result written over a pending response");

endmodule

// File: tb/tb_biquad_highpass_df2_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_highpass_df2_unit: self-checking bench for the biquad highpass
// A table of directed requests covers the reset state, sample extremes,
// delay and output saturation, ignored register indexes and excess register
// bits. Several random phases follow, each with its own coefficient setting
// and one of four idling patterns. Each result is checked against its table
// value or an in-bench fixed-point prediction of the filter.
// ----------------------------------------------------------------------------
module tb_biquad_highpass_df2_unit;

   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES  = 80;    // idle time after the last result, to catch extra results
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 225;

   localparam longint DELAY_MIN = -(longint'(1) <<< 31);
   localparam longint DELAY_MAX = (longint'(1) <<< 31) - 1;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [bq_pkg::CSR_IDX_W-1:0]         index;
      logic [bq_pkg::CSR_DATA_W-1:0]        data;
      logic signed [bq_pkg::SAMPLE_W-1:0]   sample;
      logic                                 typed;
      logic signed [bq_pkg::SAMPLE_W-1:0]   want;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bench-side drivers of the channel inputs
   logic                                 req_valid_q  = 1'b0;
   logic signed [bq_pkg::SAMPLE_W-1:0]   req_sample_q = '0;
   logic                                 rsp_ready_q  = 1'b0;
   logic                                 csr_valid_q  = 1'b0;
   logic [bq_pkg::CSR_IDX_W-1:0]         csr_index_q  = '0;
   logic [bq_pkg::CSR_DATA_W-1:0]        csr_data_q   = '0;

   bq_req_if req_bus ();
   bq_rsp_if rsp_bus ();
   bq_csr_if csr_bus ();

   assign req_bus.valid     = req_valid_q;
   assign req_bus.sample_in = req_sample_q;
   assign rsp_bus.ready     = rsp_ready_q;
   assign csr_bus.valid     = csr_valid_q;
   assign csr_bus.index     = csr_index_q;
   assign csr_bus.data      = csr_data_q;

   biquad_highpass_df2_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // predicted filter state and register contents
   bq_pkg::cfg_type                coef_set;
   logic signed [31:0]             delay_near;
   logic signed [31:0]             delay_far;
   logic signed [15:0]             expected_samples[$];
   logic signed [15:0]             want_sample;

   stim_row_type                   directed_rows[$];
   int                             mismatch_count  = 0;
   int                             samples_sent    = 0;
   int                             results_checked = 0;
   int                             writes_done     = 0;
   int                             send_idle_pct   = 0;
   int                             rsp_stall_pct   = 0;
   int                             quiet_cycles    = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic longint round_half_up(input longint value, input int shift);
      return (value + (longint'(1) <<< (shift - 1))) >>> shift;
   endfunction

   function automatic longint clamp_to(input longint value, input longint lo,
                                       input longint hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // one filter step: feedback, feedforward, gain, then shift the delay line
   function automatic logic signed [15:0] predict_highpass(input logic signed [15:0] x);
      longint a1, a2, b0, gain, z1, z2, acc, m, w, v, y;
      a1   = longint'($signed(coef_set.coef_a1));
      a2   = longint'($signed(coef_set.coef_a2));
      b0   = longint'($signed(coef_set.coef_b0));
      gain = longint'(coef_set.out_gain);
      z1   = longint'(delay_near);
      z2   = longint'(delay_far);
      acc  = (longint'(x) <<< 24) - a1 * z1 - a2 * z2;
      m    = clamp_to(round_half_up(acc, 16), DELAY_MIN, DELAY_MAX);
      w    = m - 2 * z1 + z2;
      v    = round_half_up(w * b0, 16);
      y    = clamp_to(round_half_up(v * gain, 24), -32768, 32767);
      delay_far  = delay_near;
      delay_near = m[31:0];
      return y[15:0];
   endfunction

   // register update as seen by the datapath; unknown indexes fall through
   function automatic void apply_register(input logic [bq_pkg::CSR_IDX_W-1:0] index,
                                          input logic [bq_pkg::CSR_DATA_W-1:0] data);
      case (index)
         bq_pkg::REG_COEF_A1:  coef_set.coef_a1  = data[bq_pkg::COEF_W-1:0];
         bq_pkg::REG_COEF_A2:  coef_set.coef_a2  = data[bq_pkg::COEF_W-1:0];
         bq_pkg::REG_COEF_B0:  coef_set.coef_b0  = data[bq_pkg::COEF_W-1:0];
         bq_pkg::REG_OUT_GAIN: coef_set.out_gain = data[bq_pkg::GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic stim_row_type sample_row(input logic signed [15:0] s);
      stim_row_type row;
      row        = '0;
      row.kind   = ROW_SAMPLE;
      row.sample = s;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic signed [15:0] s,
                                                input logic signed [15:0] want);
      stim_row_type row;
      row       = sample_row(s);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_type write_row(input logic [bq_pkg::CSR_IDX_W-1:0] index,
                                              input logic [bq_pkg::CSR_DATA_W-1:0] data);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.data  = data;
      return row;
   endfunction

   // present one request, hold it until taken, then maybe go idle a while
   task automatic send_sample(input logic signed [15:0] s, input logic typed,
                              input logic signed [15:0] want);
      logic signed [15:0] predicted;
      int                 gap;
      req_valid_q  <= 1'b1;
      req_sample_q <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_highpass(s);
      expected_samples.push_back(typed ? want : predicted);
      samples_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid_q <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // registers change only with the datapath drained
   task automatic write_register(input logic [bq_pkg::CSR_IDX_W-1:0] index,
                                 input logic [bq_pkg::CSR_DATA_W-1:0] data);
      if (req_valid_q) req_valid_q <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid_q <= 1'b1;
      csr_index_q <= index;
      csr_data_q  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_register(index, data);
      writes_done++;
      csr_valid_q <= 1'b0;
   endtask

   function automatic int pick_coef_extreme();
      case ($urandom_range(0, 2))
         0:       return -131072;
         1:       return 131071;
         default: return 0;
      endcase
   endfunction

   // coefficient setting for one random phase
   task automatic configure_phase(input int mode);
      real r, c, a1_r, a2_r;
      int  a1_q, a2_q, b0_q, gain_q;
      case (mode) inside
         0, 1: begin
            // stable pole pair, zeros at dc, unity gain near nyquist
            r      = 0.5 + 0.49 * $urandom_range(0, 1000) / 1000.0;
            c      = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
            a1_r   = -2.0 * r * c;
            a2_r   = r * r;
            a1_q   = $rtoi(a1_r * 65536.0);
            a2_q   = $rtoi(a2_r * 65536.0);
            b0_q   = $rtoi((1.0 - a1_r + a2_r) / 4.0 * 65536.0);
            gain_q = (mode == 0) ? 32768 + $urandom_range(0, 65536)
                                 : $urandom_range(0, 1048575);
            write_register(bq_pkg::REG_COEF_A1, a1_q);
            write_register(bq_pkg::REG_COEF_A2, a2_q);
            write_register(bq_pkg::REG_COEF_B0, b0_q);
            write_register(bq_pkg::REG_OUT_GAIN, gain_q);
         end
         2: begin
            // raw words, excess bits random, plus a write nobody decodes
            write_register(bq_pkg::REG_COEF_A1, $urandom());
            write_register(bq_pkg::REG_COEF_A2, $urandom());
            write_register(bq_pkg::REG_COEF_B0, $urandom());
            write_register(bq_pkg::REG_OUT_GAIN, $urandom());
            write_register(bq_pkg::CSR_IDX_W'($urandom_range(4, 15)), $urandom());
         end
         default: begin
            a1_q = pick_coef_extreme();
            a2_q = pick_coef_extreme();
            b0_q = pick_coef_extreme();
            case ($urandom_range(0, 2))
               0:       gain_q = 0;
               1:       gain_q = 1048575;
               default: gain_q = 65536;
            endcase
            write_register(bq_pkg::REG_COEF_A1, a1_q);
            write_register(bq_pkg::REG_COEF_A2, a2_q);
            write_register(bq_pkg::REG_COEF_B0, b0_q);
            write_register(bq_pkg::REG_OUT_GAIN, gain_q);
         end
      endcase
   endtask

   function automatic logic signed [15:0] draw_sample();
      case ($urandom_range(0, 9)) inside
         6, 7:    return 16'($signed($urandom_range(0, 511)) - 256);
         8:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         9:       return '0;
         default: return 16'($urandom());
      endcase
   endfunction

   // response side: random back-pressure and comparison with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready_q) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("result with no pending request", rsp_bus.sample_out, 0);
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_bus.sample_out !== want_sample)
                  report_mismatch("sample_out", rsp_bus.sample_out, want_sample);
               results_checked++;
            end
         end
         rsp_ready_q <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus
   initial begin
      coef_set.coef_a1  = '0;
      coef_set.coef_a2  = '0;
      coef_set.coef_b0  = 18'sd65536;
      coef_set.out_gain = 20'd65536;
      delay_near        = '0;
      delay_far         = '0;

      // reset values give y = x - 2*z1 + z2 in sample units
      directed_rows.push_back(checked_row(16'sh7fff, 16'sh7fff));
      directed_rows.push_back(checked_row(16'sh8000, 16'sh8000));
      directed_rows.push_back(checked_row(16'sh0000, 16'sh7fff));
      directed_rows.push_back(checked_row(16'sh0000, 16'sh8000));
      directed_rows.push_back(checked_row(16'sh0000, 16'sh0000));
      // zero gain mutes the output
      directed_rows.push_back(write_row(bq_pkg::REG_OUT_GAIN, 32'h0000_0000));
      directed_rows.push_back(checked_row(16'sd12345, 16'sh0000));
      directed_rows.push_back(checked_row(16'sh8000, 16'sh0000));
      // indexes above the map are dropped
      directed_rows.push_back(write_row(4'd15, 32'hffff_ffff));
      directed_rows.push_back(write_row(4'd4, 32'h0000_0000));
      // excess bits above each register width are dropped
      directed_rows.push_back(write_row(bq_pkg::REG_OUT_GAIN, 32'hffff_ffff));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_B0, 32'hfffe_0000));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_A1, 32'h0002_0000));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_A2, 32'hfffe_0000));
      // runaway feedback drives the delay words into saturation
      repeat (6) directed_rows.push_back(sample_row(16'sh7fff));
      repeat (2) directed_rows.push_back(sample_row(16'sh8000));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_A1, 32'h0001_ffff));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_A2, 32'h0001_ffff));
      directed_rows.push_back(write_row(bq_pkg::REG_COEF_B0, 32'h0001_ffff));
      directed_rows.push_back(sample_row(16'sh8000));
      directed_rows.push_back(sample_row(16'sh7fff));
      directed_rows.push_back(sample_row(16'sh0001));
      directed_rows.push_back(sample_row(16'shffff));
      repeat (2) directed_rows.push_back(sample_row(16'sh0000));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].index, directed_rows[i].data);
         else
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].want);
      end

      // random phases: setting mode and idling pattern vary independently
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase % 4);
         case ((phase / 2) % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 83; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(draw_sample(), 1'b0, '0);
      end

      // drain
      if (req_valid_q) req_valid_q <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch("results missing at end", expected_samples.size(), 0);

      $display("covered %0d samples (%0d directed rows) and %0d register writes",
               samples_sent, directed_rows.size(), writes_done);
      $display("%0d results compared over %0d random settings", results_checked,
               RANDOM_PHASES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/bq_pkg.sv
hdl/bq_ifs.sv
hdl/bq_csr.sv
hdl/bq_smac.sv
hdl/biquad_highpass_df2_unit.sv
tb/tb_biquad_highpass_df2_unit.sv
